/* sv/bsws_pkg.sv */
// Shared types, constants and helpers for the bounded stack with search.
`timescale 1ns / 1ps

package bsws_pkg;

    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int DATA_W      = 32;
    localparam int POS_W       = 5;
    localparam int CAP_W       = 5;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
    localparam int OUT_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_SEARCH = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_PUSHED    = 3'd0,
        STAT_POPPED    = 3'd1,
        STAT_OVERFLOW  = 3'd2,
        STAT_UNDERFLOW = 3'd3,
        STAT_FOUND     = 3'd4,
        STAT_NOTFOUND  = 3'd5,
        STAT_EMPTY     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_WAIT,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   data;
        logic [POS_W-1:0]    position;
        logic                last;
    } res_t;

    // Position field keeps the low bits of a 1-based entry number.
    function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[POS_W-1:0];
    endfunction

endpackage

/* sv/bounded_stack_with_search.sv */
// Top level of the bounded stack with search: ports, capacity register, packing.
`timescale 1ns / 1ps

//  channel   direction  payload
//  s_*       in         tuser = kind, tdata = value
//  m_*       out        tuser = status, tdata = data/position, tlast = last
//  cfg_*     in         cfg_data = capacity
//
//  Push: result in the cycle after the beat. Pop: the RAM read data is registered, then loaded as the result.
//  Search: one RAM read per stored entry; the last result follows the end of the scan.
//  Results of a search leave at most one per cycle unless m_tready holds them back.
//  aresetn empties the stack and sets capacity to 16; stored words are not cleared.
//  A stalled output holds the scan; the next beat is taken only once the block is idle.

module bounded_stack_with_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bsws_pkg::CAP_W-1:0]          cfg_data,    // capacity
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bsws_pkg::DATA_W-1:0]         s_tdata,     // [31:0] value
    input  logic [bsws_pkg::KIND_W-1:0]         s_tuser,     // [1:0] kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bsws_pkg::OUT_TDATA_W-1:0]    m_tdata,     // [31:0] data, [36:32] position
    output logic [bsws_pkg::STATUS_W-1:0]       m_tuser,     // [2:0] status
    output logic                                m_tlast
);

    logic [bsws_pkg::CAP_W-1:0] cap_reg;
    bsws_pkg::res_t             res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= bsws_pkg::CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    bsws_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cap     (cap_reg),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_kind  (bsws_pkg::kind_t'(s_tuser)),
        .s_value (s_tdata),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    assign m_tdata = bsws_pkg::OUT_TDATA_W'({res.position, res.data});
    assign m_tuser = res.status;
    assign m_tlast = res.last;

endmodule

/* sv/bsws_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bsws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // hold read data when no read is issued
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/bsws_core.sv */
// Stack controller: entry count, push/pop access, search scan and result register.
`timescale 1ns / 1ps

module bsws_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [bsws_pkg::CAP_W-1:0]    cap,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bsws_pkg::kind_t               s_kind,
    input  logic [bsws_pkg::DATA_W-1:0]   s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bsws_pkg::res_t                m_res
);

    bsws_pkg::state_t state_reg, state_next;
    logic [bsws_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [bsws_pkg::DATA_W-1:0] key_reg, key_next;
    logic [bsws_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                        cmp_vld_reg, cmp_vld_next;
    logic [bsws_pkg::CNT_W-1:0]  cmp_pos_reg, cmp_pos_next;
    logic                        pend_vld_reg, pend_vld_next;
    logic [bsws_pkg::CNT_W-1:0]  pend_pos_reg, pend_pos_next;
    logic [bsws_pkg::NRES_W-1:0] nmatch_reg, nmatch_next;
    logic                        m_valid_reg, m_valid_next;
    bsws_pkg::res_t              res_reg, res_next;

    logic                         ram_we, ram_re;
    logic [bsws_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [bsws_pkg::DATA_W-1:0]  ram_wdata, ram_rdata;

    logic                         slot_free, accept, full, match, stall;
    logic                         load;
    bsws_pkg::res_t               load_res;
    logic [31:0]                  cap_ext, lim;
    logic [bsws_pkg::CNT_W-1:0]   cnt_dec;

    bsws_ram #(
        .WIDTH (bsws_pkg::DATA_W),
        .DEPTH (bsws_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cap_ext   = 32'(cap);
    assign lim       = (cap_ext > 32'(bsws_pkg::DEPTH)) ? 32'(bsws_pkg::DEPTH) : cap_ext;
    assign full      = 32'(count_reg) >= lim;
    assign cnt_dec   = count_reg - 1'b1;
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == bsws_pkg::ST_IDLE) && slot_free;
    assign accept    = s_valid && s_ready;
    assign match     = cmp_vld_reg && (ram_rdata == key_reg)
                       && (32'(nmatch_reg) < 32'(bsws_pkg::MAX_RESULTS));
    // a second match cannot retire until the pending one has a free slot
    assign stall     = match && pend_vld_reg && !slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bsws_pkg::ST_IDLE;
            count_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cmp_vld_reg  <= cmp_vld_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        cmp_pos_reg  <= cmp_pos_next;
        pend_pos_reg <= pend_pos_next;
        nmatch_reg   <= nmatch_next;
        res_reg      <= res_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        key_next      = key_reg;
        idx_next      = idx_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_pos_next  = cmp_pos_reg;
        pend_vld_next = pend_vld_reg;
        pend_pos_next = pend_pos_reg;
        nmatch_next   = nmatch_reg;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[bsws_pkg::ADDR_W-1:0];
        ram_wdata     = s_value;
        ram_re        = 1'b0;
        ram_raddr     = cnt_dec[bsws_pkg::ADDR_W-1:0];
        load          = 1'b0;
        load_res      = '{status: bsws_pkg::STAT_NOTFOUND, data: '0, position: '0,
                          last: 1'b1};

        case (state_reg)
            bsws_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        bsws_pkg::KIND_PUSH: begin
                            load = 1'b1;
                            if (full) begin
                                load_res.status = bsws_pkg::STAT_OVERFLOW;
                            end else begin
                                ram_we          = 1'b1;
                                count_next      = count_reg + 1'b1;
                                load_res.status = bsws_pkg::STAT_PUSHED;
                                load_res.data   = s_value;
                            end
                        end
                        bsws_pkg::KIND_POP: begin
                            if (count_reg == '0) begin
                                load            = 1'b1;
                                load_res.status = bsws_pkg::STAT_UNDERFLOW;
                            end else begin
                                ram_re     = 1'b1;
                                count_next = cnt_dec;
                                state_next = bsws_pkg::ST_POP_WAIT;
                            end
                        end
                        bsws_pkg::KIND_SEARCH: begin
                            if (count_reg == '0) begin
                                load            = 1'b1;
                                load_res.status = bsws_pkg::STAT_EMPTY;
                            end else begin
                                key_next      = s_value;
                                idx_next      = '0;
                                cmp_vld_next  = 1'b0;
                                pend_vld_next = 1'b0;
                                nmatch_next   = '0;
                                state_next    = bsws_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            // unused kind: drop the beat
                        end
                    endcase
                end
            end
            bsws_pkg::ST_POP_WAIT: begin
                if (slot_free) begin
                    load            = 1'b1;
                    load_res.status = bsws_pkg::STAT_POPPED;
                    load_res.data   = ram_rdata;
                    state_next      = bsws_pkg::ST_IDLE;
                end
            end
            bsws_pkg::ST_SCAN: begin
                if (!stall) begin
                    if (match) begin
                        // release the previous match; it is not the final one
                        if (pend_vld_reg) begin
                            load              = 1'b1;
                            load_res.status   = bsws_pkg::STAT_FOUND;
                            load_res.data     = key_reg;
                            load_res.position = bsws_pkg::to_pos(pend_pos_reg);
                            load_res.last     = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_pos_next = cmp_pos_reg;
                        nmatch_next   = nmatch_reg + 1'b1;
                    end
                    if (idx_reg < count_reg) begin
                        ram_re       = 1'b1;
                        ram_raddr    = idx_reg[bsws_pkg::ADDR_W-1:0];
                        idx_next     = idx_reg + 1'b1;
                        cmp_vld_next = 1'b1;
                        cmp_pos_next = idx_reg + 1'b1;
                    end else begin
                        cmp_vld_next = 1'b0;
                        if (!cmp_vld_reg) begin
                            state_next = bsws_pkg::ST_FINISH;
                        end
                    end
                end
            end
            bsws_pkg::ST_FINISH: begin
                if (slot_free) begin
                    load = 1'b1;
                    if (pend_vld_reg) begin
                        load_res.status   = bsws_pkg::STAT_FOUND;
                        load_res.data     = key_reg;
                        load_res.position = bsws_pkg::to_pos(pend_pos_reg);
                    end
                    pend_vld_next = 1'b0;
                    state_next    = bsws_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bsws_pkg::ST_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (load) begin
            m_valid_next = 1'b1;
            res_next     = load_res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_kind == bsws_pkg::KIND_PUSH && !full)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not advance the entry count");

    a_scan_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bsws_pkg::ST_SCAN) |=> $stable(count_reg))
        else $error("entry count moved during a search");

    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == bsws_pkg::ST_IDLE))
        else $error("stack write outside idle");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> ($stable(cmp_pos_reg) && $stable(idx_reg) && cmp_vld_reg))
        else $error("compare stage moved while stalled");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(res_reg)))
        else $error("pending result overwritten");

endmodule
